>>> sv/cpi_pkg.sv
`default_nettype none
package cpi_pkg;

  // field widths (Q11.4 coordinates, unsigned radii)
  localparam int CoordW = 16;
  localparam int RadW   = 15;
  // intermediate widths
  localparam int DiffW  = CoordW + 1;        // center deltas
  localparam int D2W    = 2 * CoordW + 1;    // squared center distance
  localparam int KW     = D2W + 2;           // r1^2 - r2^2 + D2
  localparam int RadicW = 64;                // product under the root
  localparam int RootW  = RadicW / 2;        // floor root
  localparam int NumW   = 53;                // numerators and dividends
  localparam int DenW   = D2W + 1;           // 2 * D2
  localparam int QuoW   = 17;                // quotient magnitude
  localparam int PtW    = CoordW + 3;        // unsaturated point coordinate
  localparam int ErrW   = PtW + 1;           // point minus reference
  localparam int Lanes  = 4;                 // ax, ay, bx, by

  typedef struct packed {
    logic signed [CoordW-1:0] first_center_x;
    logic signed [CoordW-1:0] first_center_y;
    logic        [RadW-1:0]   first_radius;
    logic signed [CoordW-1:0] second_center_x;
    logic signed [CoordW-1:0] second_center_y;
    logic        [RadW-1:0]   second_radius;
    logic signed [CoordW-1:0] ref_x;
    logic signed [CoordW-1:0] ref_y;
  } in_beat_t;

  typedef struct packed {
    logic                     intersects;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } out_beat_t;

  // carried alongside the root pipeline
  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] rx;
    logic signed [CoordW-1:0] ry;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic signed [KW-1:0]     k;
    logic        [D2W-1:0]    d2;
  } sb_root_t;

  // carried alongside the dividers
  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] rx;
    logic signed [CoordW-1:0] ry;
    logic        [Lanes-1:0]  neg;
  } sb_div_t;

endpackage
`default_nettype wire

>>> sv/cpi_isqrt.sv
`default_nettype none
// Pipelined floor square root, one root bit per stage, MSB first.
module cpi_isqrt (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic [cpi_pkg::RadicW-1:0]         radicand_i,
  input  wire cpi_pkg::sb_root_t                  side_i,
  output logic                                    valid_o,
  output logic [cpi_pkg::RootW-1:0]               root_o,
  output cpi_pkg::sb_root_t                       side_o
);

  localparam int N = cpi_pkg::RootW;
  localparam int W = cpi_pkg::RadicW;

  logic [W-1:0]      rem_q  [N];
  logic [N-1:0]      root_q [N];
  logic              v_q    [N];
  cpi_pkg::sb_root_t side_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam int J = N - 1 - g;
    logic [W-1:0]      rem_in;
    logic [N-1:0]      root_in;
    logic              v_in;
    cpi_pkg::sb_root_t side_in;
    logic [W:0]        term;
    logic [W-1:0]      rem_d;
    logic [N-1:0]      root_d;

    if (g == 0) begin : g_first
      assign rem_in  = radicand_i;
      assign root_in = '0;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign v_in    = v_q[g-1];
      assign side_in = side_q[g-1];
    end

    // (r + 2^j)^2 - r^2 = r*2^(j+1) + 2^(2j)
    always_comb begin
      term = ((W+1)'(root_in) << (J + 1)) + ((W+1)'(1) << (2 * J));
      if ({1'b0, rem_in} >= term) begin
        rem_d  = rem_in - term[W-1:0];
        root_d = root_in | (N'(1) << J);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule
`default_nettype wire

>>> sv/cpi_div.sv
`default_nettype none
// Four-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module cpi_div (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        en_i,
  input  wire logic                                        valid_i,
  input  wire logic [cpi_pkg::Lanes-1:0][cpi_pkg::NumW-1:0] dividend_i,
  input  wire logic [cpi_pkg::DenW-1:0]                    den_i,
  input  wire cpi_pkg::sb_div_t                            side_i,
  output logic                                             valid_o,
  output logic [cpi_pkg::Lanes-1:0][cpi_pkg::QuoW-1:0]     quo_o,
  output cpi_pkg::sb_div_t                                 side_o
);

  localparam int N = cpi_pkg::QuoW;
  localparam int W = cpi_pkg::NumW;
  localparam int L = cpi_pkg::Lanes;

  logic [L-1:0][W-1:0]         rem_q  [N];
  logic [L-1:0][N-1:0]         quo_q  [N];
  logic [cpi_pkg::DenW-1:0]    den_q  [N];
  logic                        v_q    [N];
  cpi_pkg::sb_div_t            side_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam int J = N - 1 - g;
    logic [L-1:0][W-1:0]      rem_in;
    logic [L-1:0][N-1:0]      quo_in;
    logic [cpi_pkg::DenW-1:0] den_in;
    logic                     v_in;
    cpi_pkg::sb_div_t         side_in;
    logic [W-1:0]             shifted;
    logic [L-1:0][W-1:0]      rem_d;
    logic [L-1:0][N-1:0]      quo_d;

    if (g == 0) begin : g_first
      assign rem_in  = dividend_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign den_in  = den_q[g-1];
      assign v_in    = v_q[g-1];
      assign side_in = side_q[g-1];
    end

    // trial subtract of the divisor at this bit weight
    always_comb begin
      shifted = W'(den_in) << J;
      for (int l = 0; l < L; l++) begin
        if (rem_in[l] >= shifted) begin
          rem_d[l] = rem_in[l] - shifted;
          quo_d[l] = quo_in[l] | (N'(1) << J);
        end else begin
          rem_d[l] = rem_in[l];
          quo_d[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        quo_q[g]  <= quo_d;
        den_q[g]  <= den_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign side_o  = side_q[N-1];

endmodule
`default_nettype wire

>>> sv/circle_pair_intersection_point_top.sv
`default_nettype none
// Circle pair intersection point. Each input beat carries two circles and a
// reference point (Q11.4); each output beat says whether the circles meet and
// gives the intersection nearer the reference (the second one on a tie), or
// the first center when they do not meet, saturated to 16 bits. The unit is
// fully pipelined: it takes one beat per cycle while in_stall_o is low and
// returns results in order. The 32-stage square root and the 17-stage
// divider each resolve one bit per stage. A two-entry output stage (output
// register plus skid) keeps input acceptance registered; in_stall_o rises
// only after the skid entry has filled.
module circle_pair_intersection_point_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire cpi_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output cpi_pkg::out_beat_t      out_data_o
);

  localparam int CW = cpi_pkg::CoordW;
  localparam int DW = cpi_pkg::DiffW;
  localparam int SW = 2 * CW;                 // one squared delta
  localparam int RW = cpi_pkg::RadW;
  localparam int RSW = 2 * RW;                // squared radius
  localparam int D2W = cpi_pkg::D2W;
  localparam int KW = cpi_pkg::KW;
  localparam int NW = cpi_pkg::NumW;
  localparam int PW = cpi_pkg::PtW;
  localparam int EW = cpi_pkg::ErrW;
  localparam int L = cpi_pkg::Lanes;
  localparam int DistW = 2 * EW + 1;

  logic en;
  logic skid_full_q;

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  // stage 1: input register
  logic               v1_q;
  cpi_pkg::in_beat_t  p1_q;

  // stage 2: deltas and radius sum/difference
  logic                 v2_q;
  logic signed [DW-1:0] dx2_q, dy2_q;
  logic [RW:0]          sum2_q;
  logic signed [RW:0]   dif2_q;
  logic [RW-1:0]        r1_2_q, r2_2_q;
  logic signed [CW-1:0] x1_2_q, y1_2_q, rx2_q, ry2_q;

  // stage 3: squares
  logic                 v3_q;
  logic [SW-1:0]        dxx3_q, dyy3_q;
  logic [2*RW+1:0]      ss3_q;
  logic [RSW-1:0]       dd3_q, r1s3_q, r2s3_q;
  logic signed [DW-1:0] dx3_q, dy3_q;
  logic signed [CW-1:0] x1_3_q, y1_3_q, rx3_q, ry3_q;

  // stage 4: squared distance
  logic                 v4_q;
  logic [D2W-1:0]       d2_4_q;
  logic [2*RW+1:0]      ss4_q;
  logic [RSW-1:0]       dd4_q;
  logic signed [RSW:0]  rr4_q;
  logic signed [DW-1:0] dx4_q, dy4_q;
  logic signed [CW-1:0] x1_4_q, y1_4_q, rx4_q, ry4_q;

  // stage 5: intersection test and factors of the radicand
  logic                 v5_q;
  logic                 hit5_q;
  logic [SW-1:0]        fa5_q, fb5_q;
  logic signed [KW-1:0] k5_q;
  logic [D2W-1:0]       d2_5_q;
  logic signed [DW-1:0] dx5_q, dy5_q;
  logic signed [CW-1:0] x1_5_q, y1_5_q, rx5_q, ry5_q;

  // stage 6: radicand
  logic                           v6_q;
  logic [cpi_pkg::RadicW-1:0]     q6_q;
  cpi_pkg::sb_root_t              sb6_q;

  logic                   root_v;
  logic [cpi_pkg::RootW-1:0] root_s;
  cpi_pkg::sb_root_t      root_sb;

  // combinational stage products
  logic signed [2*DW-1:0] dxx_w, dyy_w;
  logic signed [2*RW+1:0] dd_w;

  always_comb begin
    dxx_w = dx2_q * dx2_q;
    dyy_w = dy2_q * dy2_q;
    dd_w  = dif2_q * dif2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // front pipeline datapath
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= in_data_i;

      dx2_q  <= DW'(p1_q.second_center_x) - DW'(p1_q.first_center_x);
      dy2_q  <= DW'(p1_q.second_center_y) - DW'(p1_q.first_center_y);
      sum2_q <= (RW+1)'(p1_q.first_radius) + (RW+1)'(p1_q.second_radius);
      dif2_q <= $signed({1'b0, p1_q.first_radius}) - $signed({1'b0, p1_q.second_radius});
      r1_2_q <= p1_q.first_radius;
      r2_2_q <= p1_q.second_radius;
      x1_2_q <= p1_q.first_center_x;
      y1_2_q <= p1_q.first_center_y;
      rx2_q  <= p1_q.ref_x;
      ry2_q  <= p1_q.ref_y;

      dxx3_q <= dxx_w[SW-1:0];
      dyy3_q <= dyy_w[SW-1:0];
      ss3_q  <= sum2_q * sum2_q;
      dd3_q  <= dd_w[RSW-1:0];
      r1s3_q <= r1_2_q * r1_2_q;
      r2s3_q <= r2_2_q * r2_2_q;
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      x1_3_q <= x1_2_q;
      y1_3_q <= y1_2_q;
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;

      d2_4_q <= D2W'(dxx3_q) + D2W'(dyy3_q);
      ss4_q  <= ss3_q;
      dd4_q  <= dd3_q;
      rr4_q  <= $signed({1'b0, r1s3_q}) - $signed({1'b0, r2s3_q});
      dx4_q  <= dx3_q;
      dy4_q  <= dy3_q;
      x1_4_q <= x1_3_q;
      y1_4_q <= y1_3_q;
      rx4_q  <= rx3_q;
      ry4_q  <= ry3_q;

      hit5_q <= (d2_4_q != '0) && (d2_4_q <= D2W'(ss4_q)) && (d2_4_q >= D2W'(dd4_q));
      fa5_q  <= ss4_q[SW-1:0] - d2_4_q[SW-1:0];
      fb5_q  <= d2_4_q[SW-1:0] - SW'(dd4_q);
      k5_q   <= $signed({2'b00, d2_4_q}) + KW'(rr4_q);
      d2_5_q <= d2_4_q;
      dx5_q  <= dx4_q;
      dy5_q  <= dy4_q;
      x1_5_q <= x1_4_q;
      y1_5_q <= y1_4_q;
      rx5_q  <= rx4_q;
      ry5_q  <= ry4_q;

      q6_q      <= fa5_q * fb5_q;
      sb6_q.hit <= hit5_q;
      sb6_q.x1  <= x1_5_q;
      sb6_q.y1  <= y1_5_q;
      sb6_q.rx  <= rx5_q;
      sb6_q.ry  <= ry5_q;
      sb6_q.dx  <= dx5_q;
      sb6_q.dy  <= dy5_q;
      sb6_q.k   <= k5_q;
      sb6_q.d2  <= d2_5_q;
    end
  end

  cpi_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v6_q),
    .radicand_i (q6_q),
    .side_i     (sb6_q),
    .valid_o    (root_v),
    .root_o     (root_s),
    .side_o     (root_sb)
  );

  // stage 7: products with K and S
  logic                   v7_q;
  logic signed [NW-2:0]   pxk7_q, pys7_q, pyk7_q, pxs7_q;
  cpi_pkg::sb_root_t      sb7_q;

  // stage 8: numerators
  logic                   v8_q;
  logic signed [NW-1:0]   n8_q [L];
  cpi_pkg::sb_root_t      sb8_q;

  // stage 9: dividends as magnitude plus D2 (rounding half up)
  logic                           v9_q;
  logic [L-1:0][NW-1:0]           dvd9_q;
  logic [cpi_pkg::DenW-1:0]       den9_q;
  cpi_pkg::sb_div_t               sb9_q;

  logic                           div_v;
  logic [L-1:0][cpi_pkg::QuoW-1:0] div_quo;
  cpi_pkg::sb_div_t               div_sb;

  logic signed [cpi_pkg::RootW:0] s_w;
  logic signed [NW-1:0]           d2_w;
  logic signed [NW-2:0]           pxk_w, pys_w, pyk_w, pxs_w;

  always_comb begin
    s_w   = $signed({1'b0, root_s});
    d2_w  = $signed(NW'(sb8_q.d2));
    pxk_w = (NW-1)'(root_sb.dx * root_sb.k);
    pys_w = (NW-1)'(root_sb.dy * s_w);
    pyk_w = (NW-1)'(root_sb.dy * root_sb.k);
    pxs_w = (NW-1)'(root_sb.dx * s_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v7_q <= root_v;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxk7_q <= pxk_w;
      pys7_q <= pys_w;
      pyk7_q <= pyk_w;
      pxs7_q <= pxs_w;
      sb7_q  <= root_sb;

      // lane order: ax, ay, bx, by
      n8_q[0] <= NW'(pxk7_q) + NW'(pys7_q);
      n8_q[1] <= NW'(pyk7_q) - NW'(pxs7_q);
      n8_q[2] <= NW'(pxk7_q) - NW'(pys7_q);
      n8_q[3] <= NW'(pyk7_q) + NW'(pxs7_q);
      sb8_q   <= sb7_q;

      for (int l = 0; l < L; l++) begin
        dvd9_q[l]    <= n8_q[l][NW-1] ? NW'(d2_w - n8_q[l]) : NW'(d2_w + n8_q[l]);
        sb9_q.neg[l] <= n8_q[l][NW-1];
      end
      den9_q   <= {sb8_q.d2, 1'b0};
      sb9_q.hit <= sb8_q.hit;
      sb9_q.x1  <= sb8_q.x1;
      sb9_q.y1  <= sb8_q.y1;
      sb9_q.rx  <= sb8_q.rx;
      sb9_q.ry  <= sb8_q.ry;
    end
  end

  cpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v9_q),
    .dividend_i (dvd9_q),
    .den_i      (den9_q),
    .side_i     (sb9_q),
    .valid_o    (div_v),
    .quo_o      (div_quo),
    .side_o     (div_sb)
  );

  // stage 10: candidate points
  logic                 v10_q, hit10_q;
  logic signed [PW-1:0] pt10_q [L];
  logic signed [CW-1:0] x1_10_q, y1_10_q, rx10_q, ry10_q;

  // stage 11: offsets to the reference
  logic                 v11_q, hit11_q;
  logic signed [PW-1:0] pt11_q [L];
  logic signed [EW-1:0] er11_q [L];
  logic signed [CW-1:0] x1_11_q, y1_11_q;

  // stage 12: squared offsets
  logic                   v12_q, hit12_q;
  logic signed [PW-1:0]   pt12_q [L];
  logic [2*EW-1:0]        sq12_q [L];
  logic signed [CW-1:0]   x1_12_q, y1_12_q;

  // stage 13: distances
  logic                   v13_q, hit13_q;
  logic signed [PW-1:0]   pt13_q [L];
  logic [DistW-1:0]       dist1_13_q, dist2_13_q;
  logic signed [CW-1:0]   x1_13_q, y1_13_q;

  // stage 14: chosen, saturated result
  logic                   v14_q;
  cpi_pkg::out_beat_t     res14_q;

  logic signed [PW-1:0]   off_w [L];
  logic signed [2*EW-1:0] sq_w [L];
  logic signed [PW-1:0]   selx_w, sely_w;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [PW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > PW'(2 ** (CW - 1) - 1)) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (v < -PW'(2 ** (CW - 1))) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    for (int l = 0; l < L; l++) begin
      off_w[l] = div_sb.neg[l] ? -$signed(PW'(div_quo[l])) : $signed(PW'(div_quo[l]));
      sq_w[l]  = er11_q[l] * er11_q[l];
    end
    // point one only when strictly nearer
    if (dist1_13_q < dist2_13_q) begin
      selx_w = pt13_q[0];
      sely_w = pt13_q[1];
    end else begin
      selx_w = pt13_q[2];
      sely_w = pt13_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
      v13_q <= 1'b0;
      v14_q <= 1'b0;
    end else if (en) begin
      v10_q <= div_v;
      v11_q <= v10_q;
      v12_q <= v11_q;
      v13_q <= v12_q;
      v14_q <= v13_q;
    end
  end

  // back pipeline datapath
  always_ff @(posedge clk_i) begin
    if (en) begin
      pt10_q[0] <= PW'(div_sb.x1) + off_w[0];
      pt10_q[1] <= PW'(div_sb.y1) + off_w[1];
      pt10_q[2] <= PW'(div_sb.x1) + off_w[2];
      pt10_q[3] <= PW'(div_sb.y1) + off_w[3];
      hit10_q   <= div_sb.hit;
      x1_10_q   <= div_sb.x1;
      y1_10_q   <= div_sb.y1;
      rx10_q    <= div_sb.rx;
      ry10_q    <= div_sb.ry;

      er11_q[0] <= EW'(pt10_q[0]) - EW'(rx10_q);
      er11_q[1] <= EW'(pt10_q[1]) - EW'(ry10_q);
      er11_q[2] <= EW'(pt10_q[2]) - EW'(rx10_q);
      er11_q[3] <= EW'(pt10_q[3]) - EW'(ry10_q);
      pt11_q    <= pt10_q;
      hit11_q   <= hit10_q;
      x1_11_q   <= x1_10_q;
      y1_11_q   <= y1_10_q;

      for (int l = 0; l < L; l++) begin
        sq12_q[l] <= sq_w[l];
      end
      pt12_q  <= pt11_q;
      hit12_q <= hit11_q;
      x1_12_q <= x1_11_q;
      y1_12_q <= y1_11_q;

      dist1_13_q <= DistW'(sq12_q[0]) + DistW'(sq12_q[1]);
      dist2_13_q <= DistW'(sq12_q[2]) + DistW'(sq12_q[3]);
      pt13_q     <= pt12_q;
      hit13_q    <= hit12_q;
      x1_13_q    <= x1_12_q;
      y1_13_q    <= y1_12_q;

      res14_q.intersects <= hit13_q;
      res14_q.point_x    <= hit13_q ? sat_coord(selx_w) : x1_13_q;
      res14_q.point_y    <= hit13_q ? sat_coord(sely_w) : y1_13_q;
    end
  end

  // output register with one skid entry
  logic               out_valid_q;
  cpi_pkg::out_beat_t out_q, skid_q;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
        skid_full_q <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_q <= v14_q;
    end else if (v14_q) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= res14_q;
    end else begin
      skid_q <= res14_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // skid entry only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid entry full with no output beat");

  // a filled skid entry drains only when the output moves
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full_q && out_stall_i) |=> (skid_full_q && $stable(out_q)))
    else $error("skid entry lost while output stalled");

  // a new pipeline result never overwrites a held output beat
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !skid_full_q && v14_q) |=> skid_full_q)
    else $error("result dropped under output stall");

endmodule
`default_nettype wire

>>> verif/circle_pair_intersection_point_top_test.sv
`default_nettype none
module circle_pair_intersection_point_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom  = 700;
  localparam int CycleLimit = 400000;
  localparam int Latency    = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  cpi_pkg::in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  cpi_pkg::out_beat_t out_data_o;

  circle_pair_intersection_point_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #10 clk_i = ~clk_i;

  cpi_pkg::out_beat_t point_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;

  // directed rows; check_fixed marks rows whose result is typed in
  typedef struct {
    cpi_pkg::in_beat_t  beat;
    bit                 check_fixed;
    cpi_pkg::out_beat_t fixed;
  } row_t;
  row_t rows[$];

  // nearest rounding, ties away from zero
  function automatic longint div_round(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [cpi_pkg::CoordW-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[cpi_pkg::CoordW-1:0];
  endfunction

  // nearer intersection point, or first center when the circles miss
  function automatic cpi_pkg::out_beat_t nearer_point(cpi_pkg::in_beat_t b);
    cpi_pkg::out_beat_t o;
    longint x1, y1, r1, x2, y2, r2, rx, ry, dx, dy, d2, s2, f2, k, s, den;
    longint ax, ay, bx, by, e1, e2;
    longint unsigned q;
    x1 = b.first_center_x;  y1 = b.first_center_y;  r1 = b.first_radius;
    x2 = b.second_center_x; y2 = b.second_center_y; r2 = b.second_radius;
    rx = b.ref_x; ry = b.ref_y;
    dx = x2 - x1; dy = y2 - y1;
    d2 = dx * dx + dy * dy;
    s2 = (r1 + r2) * (r1 + r2);
    f2 = (r1 - r2) * (r1 - r2);
    o.intersects = 1'b0;
    o.point_x = b.first_center_x;
    o.point_y = b.first_center_y;
    if (d2 > 0 && d2 <= s2 && d2 >= f2) begin
      q = longint'(s2 - d2) * longint'(d2 - f2);
      s = floor_root(q);
      k = r1 * r1 - r2 * r2 + d2;
      den = 2 * d2;
      ax = x1 + div_round(dx * k + dy * s, den);
      ay = y1 + div_round(dy * k - dx * s, den);
      bx = x1 + div_round(dx * k - dy * s, den);
      by = y1 + div_round(dy * k + dx * s, den);
      e1 = (ax - rx) * (ax - rx) + (ay - ry) * (ay - ry);
      e2 = (bx - rx) * (bx - rx) + (by - ry) * (by - ry);
      o.intersects = 1'b1;
      if (e1 < e2) begin
        o.point_x = clamp_coord(ax); o.point_y = clamp_coord(ay);
      end else begin
        o.point_x = clamp_coord(bx); o.point_y = clamp_coord(by);
      end
    end
    return o;
  endfunction

  function automatic cpi_pkg::in_beat_t mk(int x1, int y1, int r1, int x2, int y2, int r2,
                                           int rx, int ry);
    cpi_pkg::in_beat_t b;
    b.first_center_x = x1; b.first_center_y = y1; b.first_radius = r1;
    b.second_center_x = x2; b.second_center_y = y2; b.second_radius = r2;
    b.ref_x = rx; b.ref_y = ry;
    return b;
  endfunction

  task automatic add_row(cpi_pkg::in_beat_t b, bit fx, bit hit, int px, int py);
    row_t r;
    r.beat = b;
    r.check_fixed = fx;
    r.fixed.intersects = hit;
    r.fixed.point_x = px;
    r.fixed.point_y = py;
    rows.push_back(r);
  endtask

  // mostly intersecting pairs: second center placed within reach
  function automatic cpi_pkg::in_beat_t random_pair();
    cpi_pkg::in_beat_t b;
    int unsigned mode;
    int span;
    mode = $urandom_range(0, 9);
    b = cpi_pkg::in_beat_t'({$urandom, $urandom, $urandom, $urandom});
    if (mode < 7) begin
      span = (mode < 3) ? 255 : 4095;
      b.first_radius = $urandom_range(1, span);
      b.second_radius = $urandom_range(1, span);
      b.second_center_x = b.first_center_x + $signed($urandom_range(0, 2 * span)) - span;
      b.second_center_y = b.first_center_y + $signed($urandom_range(0, 2 * span)) - span;
      b.ref_x = b.first_center_x + $signed($urandom_range(0, 2 * span)) - span;
    end else if (mode == 7) begin
      b.second_center_x = b.first_center_x;
      b.second_center_y = b.first_center_y;
    end
    return b;
  endfunction

  task automatic idle_input();
    in_valid_i <= 1'b0;
    in_data_i <= cpi_pkg::in_beat_t'({$urandom, $urandom, $urandom, $urandom});
  endtask

  // random idle stretch on the input; nothing is driven when it is empty
  task automatic wait_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n != 0) begin
      idle_input();
      repeat (n) @(posedge clk_i);
    end
  endtask

  // drive one beat and hold it until accepted
  task automatic send_beat(cpi_pkg::in_beat_t b);
    in_valid_i <= 1'b1;
    in_data_i <= b;
    point_q.push_back(nearer_point(b));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stimulus
  initial begin
    cpi_pkg::in_beat_t b;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);                   // coincident
    add_row(mk(100, -50, 10, 100, -50, 10, 0, 0), 1, 0, 100, -50);     // same circle
    add_row(mk(-32768, 32767, 5, 32767, -32768, 5, 0, 0), 1, 0, -32768, 32767);
    add_row(mk(0, 0, 10, 100, 0, 10, 0, 0), 1, 0, 0, 0);               // too far
    add_row(mk(0, 0, 100, 10, 0, 5, 0, 0), 1, 0, 0, 0);                // nested
    add_row(mk(0, 0, 50, 100, 0, 50, 0, 0), 1, 1, 50, 0);              // touching
    add_row(mk(0, 0, 100, 50, 0, 50, 0, 0), 1, 1, 100, 0);             // inner touch
    add_row(mk(0, 0, 50, 60, 0, 50, 30, 100), 1, 1, 30, 40);           // picks upper
    add_row(mk(0, 0, 50, 60, 0, 50, 30, -100), 1, 1, 30, -40);         // picks lower
    add_row(mk(0, 0, 50, 60, 0, 50, 0, 0), 0, 0, 0, 0);                // tie
    add_row(mk(32767, 32767, 32767, 32700, 32767, 32767, 32767, 32767), 0, 0, 0, 0);
    add_row(mk(-32768, -32768, 32767, -32700, -32768, 32767, -32768, 0), 0, 0, 0, 0);
    add_row(mk(-32768, -32768, 32767, 32767, 32767, 32767, 0, 0), 0, 0, 0, 0);
    add_row(mk(0, 0, 32767, 1, 0, 32767, 32767, -32768), 0, 0, 0, 0);
    add_row(mk(-1, -1, 32767, 0, 0, 0, -1, 0), 0, 0, 0, 0);
    add_row(mk(0, 0, 3, 1, 1, 2, 5, 5), 0, 0, 0, 0);
    add_row(mk(32767, -32768, 1, 32767, -32767, 1, -1, -1), 0, 0, 0, 0);

    foreach (rows[i]) begin
      send_beat(rows[i].beat);
      if (rows[i].check_fixed && nearer_point(rows[i].beat) != rows[i].fixed) begin
        $display("%0t directed row %0d: expected %h actual predictor %h", $time, i,
                 rows[i].fixed, nearer_point(rows[i].beat));
        errors++;
      end
      wait_gap();
    end

    // pause until everything has drained
    idle_input();
    wait (point_q.size() == 0);
    @(posedge clk_i);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == 200) long_hold = 1'b1;
      if (i == 400) begin
        idle_input();
        wait (point_q.size() == 0);
        @(posedge clk_i);
      end
      b = random_pair();
      send_beat(b);
      if (i % 150 < 60) begin
        // burst with no gaps
      end else if ($urandom_range(0, 1) == 0) begin
        wait_gap();
      end
    end
    idle_input();
    stim_done = 1'b1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int unsigned n;
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall_i <= 1'b1;
        for (hold = 0; hold < 300; hold++) @(posedge clk_i);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cpi_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (point_q.size() == 0) begin
        $display("%0t unexpected result beat: actual %h", $time, out_data_o);
        errors++;
      end else begin
        want = point_q.pop_front();
        if (out_data_o.intersects !== want.intersects) begin
          $display("%0t intersects: expected %0b actual %0b", $time, want.intersects,
                   out_data_o.intersects);
          errors++;
        end
        if (out_data_o.point_x !== want.point_x) begin
          $display("%0t point_x: expected %0d actual %0d", $time, want.point_x,
                   out_data_o.point_x);
          errors++;
        end
        if (out_data_o.point_y !== want.point_y) begin
          $display("%0t point_y: expected %0d actual %0d", $time, want.point_y,
                   out_data_o.point_y);
          errors++;
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    int unsigned tail;
    tail = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
      if (stim_done && point_q.size() == 0) tail++;
      else tail = 0;
      if (tail > 2 * Latency) begin
        if (errors == 0) begin
          $display("TEST PASSED");
        end else begin
          $display("TEST FAILED");
        end
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
